>>> design/pdll_pkg.sv
// ----------------------------------------------------------------------------
// pdll_pkg
// Shared types and codes of the positional doubly linked list core.
// ----------------------------------------------------------------------------
package pdll_pkg;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 8;
  localparam int AGE_W    = 8;
  localparam int NAME_W   = 32;
  localparam int PARTY_W  = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_END   = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_END   = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_LIST_FWD  = 3'd6,
    CMD_LIST_BACK = 3'd7
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_INVALID = 2'd2,
    STATUS_FULL    = 2'd3
  } status_e;

  // what a cell loads at the next edge
  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_LOAD       = 2'd1,
    OP_TAKE_LEFT  = 2'd2,
    OP_TAKE_RIGHT = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [AGE_W-1:0]   age;
    logic [NAME_W-1:0]  name_tag;
    logic [PARTY_W-1:0] party_tag;
  } rec_t;

endpackage

>>> design/pdll_if.sv
// ----------------------------------------------------------------------------
// pdll_if
// Valid/ready channels of the list core: command words in, result words out.
// ----------------------------------------------------------------------------
interface pdll_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [pdll_pkg::CMD_W-1:0]   command;
  logic [pdll_pkg::POS_W-1:0]   position;
  logic [pdll_pkg::AGE_W-1:0]   age;
  logic [pdll_pkg::NAME_W-1:0]  name_tag;
  logic [pdll_pkg::PARTY_W-1:0] party_tag;

  modport source (output valid, command, position, age, name_tag, party_tag,
                  input ready);
  modport sink   (input valid, command, position, age, name_tag, party_tag,
                  output ready);
endinterface

interface pdll_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [pdll_pkg::STATUS_W-1:0] status;
  logic [pdll_pkg::COUNT_W-1:0]  count;
  logic                         entry_valid;
  logic [pdll_pkg::COUNT_W-1:0]  entry_number;
  logic [pdll_pkg::AGE_W-1:0]    entry_age;
  logic [pdll_pkg::NAME_W-1:0]   entry_name_tag;
  logic [pdll_pkg::PARTY_W-1:0]  entry_party_tag;
  logic                         last;

  modport source (output valid, status, count, entry_valid, entry_number, entry_age,
                  entry_name_tag, entry_party_tag, last, input ready);
  modport sink   (input valid, status, count, entry_valid, entry_number, entry_age,
                  entry_name_tag, entry_party_tag, last, output ready);
endinterface

>>> design/pdll_cell.sv
// ----------------------------------------------------------------------------
// pdll_cell
// One list position: holds a record and takes it from a neighbor, from the
// load bus or keeps it, as the sequencer commands.
// ----------------------------------------------------------------------------
module pdll_cell
  import pdll_pkg::*;
(
  input  logic     clk_i,
  input  cell_op_e op_i,
  input  rec_t     left_i,
  input  rec_t     right_i,
  input  rec_t     load_i,
  output rec_t     rec_o
);

  rec_t rec_q, rec_d;

  always_comb begin
    case (op_i)
      OP_HOLD:       rec_d = rec_q;
      OP_LOAD:       rec_d = load_i;
      OP_TAKE_LEFT:  rec_d = left_i;
      OP_TAKE_RIGHT: rec_d = right_i;
      default:       rec_d = rec_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

>>> design/positional_doubly_linked_list_core.sv
// ----------------------------------------------------------------------------
// positional_doubly_linked_list_core
// Fixed-capacity positional list kept as a row of cells in list order.
//
//   channel  dir  word                                   accepted when
//   cmd_i    in   command, position, age, name, party    valid & ready
//   rsp_o    out  status, count, entry fields, last      valid & ready
//
// insert and delete shift the cells behind the position by one; one command
// gives one result word
// a listing first enters its listing state, then rotates the occupied cells one
// step a cycle while results are taken, one word per entry; the input is held
// until the last word; a new command waits until done
// a stalled result holds the sequencer and the cells in place
// reset empties the list at once; no clearing pass
// ----------------------------------------------------------------------------
module positional_doubly_linked_list_core
  import pdll_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic         clk_i,
  input logic         rst_ni,
  pdll_cmd_if.sink    cmd_i,
  pdll_rsp_if.source  rsp_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LIST = 1'b1;

  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] step_q, step_d;
  logic             back_q, back_d;

  logic                rsp_vld_q, rsp_vld_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [COUNT_W-1:0]  cnt_out_q, cnt_out_d;
  logic                ent_vld_q, ent_vld_d;
  logic [COUNT_W-1:0]  ent_num_q, ent_num_d;
  rec_t                ent_rec_q, ent_rec_d;
  logic                last_q, last_d;

  rec_t      cell_rec [CAPACITY];
  cell_op_e  cell_op  [CAPACITY];
  rec_t      load_rec;
  rec_t      tail_rec;
  rec_t      new_rec;

  logic             out_free;
  logic             accept;
  cmd_e             cmd;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_m1;
  logic [POS_W-1:0] count_ext;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] k;
  logic             do_ins, do_del, do_fwd, do_back;

  assign out_free    = !rsp_vld_q || rsp_o.ready;
  assign cmd_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept      = cmd_i.valid && cmd_i.ready;

  assign cmd       = cmd_e'(cmd_i.command);
  assign pos       = cmd_i.position;
  assign pos_m1    = pos - POS_W'(1);
  assign count_ext = POS_W'(count_q);
  assign last_idx  = IDX_W'(count_q - CNT_W'(1));
  assign new_rec   = '{age: cmd_i.age, name_tag: cmd_i.name_tag,
                       party_tag: cmd_i.party_tag};

  // the tail cell, picked by its place
  always_comb begin
    tail_rec = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (IDX_W'(j) == last_idx) begin
        tail_rec = tail_rec | cell_rec[j];
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    step_d    = step_q;
    back_d    = back_q;
    rsp_vld_d = rsp_vld_q;
    status_d  = status_q;
    cnt_out_d = cnt_out_q;
    ent_vld_d = ent_vld_q;
    ent_num_d = ent_num_q;
    ent_rec_d = ent_rec_q;
    last_d    = last_q;
    do_ins    = 1'b0;
    do_del    = 1'b0;
    do_fwd    = 1'b0;
    do_back   = 1'b0;
    k         = '0;

    if (rsp_vld_q && rsp_o.ready) begin
      rsp_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          status_d  = STATUS_OK;
          ent_vld_d = 1'b0;
          ent_num_d = '0;
          ent_rec_d = '0;
          last_d    = 1'b1;
          case (cmd)
            CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT: begin
              rsp_vld_d = 1'b1;
              if (count_q == CNT_W'(CAPACITY)) begin
                status_d = STATUS_FULL;
              end else begin
                do_ins  = 1'b1;
                count_d = count_q + CNT_W'(1);
                if (cmd == CMD_INS_FRONT || (cmd == CMD_INS_AT && pos <= POS_W'(1))) begin
                  k = '0;
                end else if (cmd == CMD_INS_END || pos_m1 >= count_ext) begin
                  k = IDX_W'(count_q);
                end else begin
                  k = IDX_W'(pos_m1);
                end
              end
            end
            CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_AT: begin
              rsp_vld_d = 1'b1;
              if (count_q == '0) begin
                status_d = STATUS_EMPTY;
              end else if (cmd == CMD_DEL_FRONT ||
                           (cmd == CMD_DEL_AT && pos == POS_W'(1))) begin
                do_del = 1'b1;
                k      = '0;
              end else if (cmd == CMD_DEL_END ||
                           (cmd == CMD_DEL_AT && pos == count_ext)) begin
                do_del = 1'b1;
                k      = last_idx;
              end else if (pos == '0 || pos > count_ext) begin
                status_d = STATUS_INVALID;
              end else begin
                do_del = 1'b1;
                k      = IDX_W'(pos_m1);
              end
              if (do_del) begin
                count_d = count_q - CNT_W'(1);
              end
            end
            CMD_LIST_FWD, CMD_LIST_BACK: begin
              if (count_q == '0) begin
                rsp_vld_d = 1'b1;
                status_d  = STATUS_EMPTY;
              end else begin
                state_d = ST_LIST;
                step_d  = '0;
                back_d  = (cmd == CMD_LIST_BACK);
              end
            end
            default: begin
              rsp_vld_d = 1'b1;
            end
          endcase
          cnt_out_d = COUNT_W'(count_d);
        end
      end
      ST_LIST: begin
        if (out_free) begin
          rsp_vld_d = 1'b1;
          status_d  = STATUS_OK;
          cnt_out_d = COUNT_W'(count_q);
          ent_vld_d = 1'b1;
          ent_num_d = COUNT_W'(step_q + CNT_W'(1));
          ent_rec_d = back_q ? tail_rec : cell_rec[0];
          last_d    = (IDX_W'(step_q) == last_idx);
          do_fwd    = !back_q;
          do_back   = back_q;
          step_d    = step_q + CNT_W'(1);
          if (IDX_W'(step_q) == last_idx) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // insert loads the new record; forward listing wraps the head to the tail end, backward the tail to the head
  always_comb begin
    if (do_ins) begin
      load_rec = new_rec;
    end else if (do_back) begin
      load_rec = tail_rec;
    end else begin
      load_rec = cell_rec[0];
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rec_t left_rec;
    rec_t right_rec;

    if (i == 0) begin : g_first
      assign left_rec = cell_rec[0];
    end else begin : g_inner_l
      assign left_rec = cell_rec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_rec = cell_rec[CAPACITY-1];
    end else begin : g_inner_r
      assign right_rec = cell_rec[i+1];
    end

    always_comb begin
      cell_op[i] = OP_HOLD;
      if (do_ins) begin
        if (IDX_W'(i) > k) begin
          cell_op[i] = OP_TAKE_LEFT;
        end else if (IDX_W'(i) == k) begin
          cell_op[i] = OP_LOAD;
        end
      end else if (do_del) begin
        if (IDX_W'(i) >= k) begin
          cell_op[i] = OP_TAKE_RIGHT;
        end
      end else if (do_fwd) begin
        if (IDX_W'(i) < last_idx) begin
          cell_op[i] = OP_TAKE_RIGHT;
        end else if (IDX_W'(i) == last_idx) begin
          cell_op[i] = OP_LOAD;
        end
      end else if (do_back) begin
        if (i == 0) begin
          cell_op[i] = OP_LOAD;
        end else if (IDX_W'(i) <= last_idx) begin
          cell_op[i] = OP_TAKE_LEFT;
        end
      end
    end

    pdll_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[i]),
      .left_i  (left_rec),
      .right_i (right_rec),
      .load_i  (load_rec),
      .rec_o   (cell_rec[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      step_q    <= '0;
      back_q    <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      step_q    <= step_d;
      back_q    <= back_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    cnt_out_q <= cnt_out_d;
    ent_vld_q <= ent_vld_d;
    ent_num_q <= ent_num_d;
    ent_rec_q <= ent_rec_d;
    last_q    <= last_d;
  end

  assign rsp_o.valid           = rsp_vld_q;
  assign rsp_o.status          = status_q;
  assign rsp_o.count           = cnt_out_q;
  assign rsp_o.entry_valid     = ent_vld_q;
  assign rsp_o.entry_number    = ent_num_q;
  assign rsp_o.entry_age       = ent_rec_q.age;
  assign rsp_o.entry_name_tag  = ent_rec_q.name_tag;
  assign rsp_o.entry_party_tag = ent_rec_q.party_tag;
  assign rsp_o.last            = last_q;

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LIST |-> step_q < count_q)
    else $error("listing step beyond entry count");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.command != CMD_LIST_FWD && cmd_i.command != CMD_LIST_BACK)
    |=> rsp_o.valid && rsp_o.last && !rsp_o.entry_valid)
    else $error("edit command did not give its single result");

  a_last_entry_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.entry_valid && rsp_o.last) |-> rsp_o.entry_number == rsp_o.count)
    else $error("final listed word does not match count");

  a_count_stable_listing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LIST |=> $stable(count_q))
    else $error("count changed during a listing");

endmodule
